@@ rtl/utcl_pkg.sv @@
// ----------------------------------------------------------------------------
// utcl_pkg
// Types, constants and small calendar helpers shared by the UTC to local
// date and time pipeline.
// ----------------------------------------------------------------------------
package utcl_pkg;

	// Register stages from the input registers to the output registers.
	localparam int NUM_STAGES = 9;

	localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
	localparam logic [17:0] LAST_DOE      = 18'd146096;
	localparam logic [17:0] DOE_CENT_1    = 18'd36524;
	localparam logic [17:0] DOE_CENT_2    = 18'd73048;
	localparam logic [17:0] DOE_CENT_3    = 18'd109572;
	localparam logic [10:0] MIN_PER_DAY   = 11'd1440;

	// Reciprocals: floor(x * R / 2^n) equals floor(x / d) over the value range.
	localparam logic [13:0] ERA_RECIP     = 14'd10486;   // /400, n = 22
	localparam logic [17:0] Q1460_RECIP   = 18'd183860;  // /1460, n = 28
	localparam logic [17:0] YEAR_RECIP    = 18'd183860;  // /365, n = 26
	localparam logic [12:0] MP_RECIP      = 13'd6854;    // /153, n = 20
	localparam logic [11:0] HOUR_RECIP    = 12'd2185;    // /60, n = 17

	typedef struct packed {
		logic [6:0]  era;    // signed era of 400 years
		logic [18:0] doe;    // signed day of era, before the carry
		logic [2:0]  carry;  // signed whole days from the time of day
	} utcl_days_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} utcl_hms_t;

	// Days from March 1 to the first day of the shifted month (March is 0).
	function automatic logic [8:0] month_start(input logic [3:0] mi);
		logic [8:0] r;
		case (mi)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Year of era divided by 100, for year of era 0..399.
	function automatic logic [1:0] div100(input logic [8:0] yoe);
		logic [1:0] r;
		if (yoe >= 9'd300) begin
			r = 2'd3;
		end else if (yoe >= 9'd200) begin
			r = 2'd2;
		end else if (yoe >= 9'd100) begin
			r = 2'd1;
		end else begin
			r = 2'd0;
		end
		return r;
	endfunction

	// Days in the era before the given year of era.
	function automatic logic [17:0] year_days(input logic [8:0] yoe);
		logic [17:0] r;
		r = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(div100(yoe));
		return r;
	endfunction

endpackage

@@ rtl/utc_to_local_datetime.sv @@
// ----------------------------------------------------------------------------
// utc_to_local_datetime
// Nine register stages carry a beat from the inputs; the last is the output.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits on out_ready, and a bubble in the output stage is filled at once.
// Reset clears the valid bits and sets the zone offset to zero.
// ----------------------------------------------------------------------------
module utc_to_local_datetime (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [10:0] utc_offset_minutes,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [13:0]        utc_year,
	input  logic [3:0]         utc_month,
	input  logic [4:0]         utc_day,
	input  logic [4:0]         utc_hour,
	input  logic [5:0]         utc_minute,
	input  logic [5:0]         utc_second,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [13:0]        local_year,
	output logic [3:0]         local_month,
	output logic [4:0]         local_day,
	output logic [4:0]         local_hour,
	output logic [5:0]         local_minute,
	output logic [5:0]         local_second
);
	import utcl_pkg::*;

	logic                  en;
	logic [NUM_STAGES-1:0] valid_s;
	logic signed [10:0]    offset_q;

	logic                  sec_wrap;
	logic [10:0]           hr_min;
	logic signed [12:0]    t_sum;
	logic signed [2:0]     carry;
	logic signed [12:0]    tm_full;
	logic [22:0]           h_prod;
	logic [10:0]           min_full;

	logic signed [12:0]    t_s1;
	logic [5:0]            sec_s1, sec_s2, sec_s3;
	logic [10:0]           tm_s2, tm_s3;
	logic signed [2:0]     carry_s2, carry_s3;
	logic [4:0]            hour_s3;
	utcl_hms_t             hms_s [4:NUM_STAGES];

	logic signed [6:0]     era_s3;
	logic signed [18:0]    doe_s3;
	utcl_days_t            days_s3;

	// Advance everything when the output stage is empty or being taken.
	assign en        = ~valid_s[NUM_STAGES-1] | out_ready;
	assign in_ready  = en;
	assign out_valid = valid_s[NUM_STAGES-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 11'sd0;
		end else if (cfg_valid) begin
			offset_q <= utc_offset_minutes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[NUM_STAGES-2:0], in_valid};
		end
	end

	// Fold a second count of 60..63 into the minutes first, so the day carry
	// only needs the minute of day.
	assign sec_wrap = (utc_second >= 6'd60);
	assign hr_min   = 11'(utc_hour) * 11'd60;
	assign t_sum    = $signed({2'b00, hr_min}) + $signed({7'b0, utc_minute})
			+ 13'(offset_q) + $signed({12'b0, sec_wrap});

	always_comb begin
		if (t_s1 < 13'sd0) begin
			carry   = -3'sd1;
			tm_full = t_s1 + $signed({2'b00, MIN_PER_DAY});
		end else if (t_s1 < $signed({2'b00, MIN_PER_DAY})) begin
			carry   = 3'sd0;
			tm_full = t_s1;
		end else if (t_s1 < $signed({1'b0, MIN_PER_DAY, 1'b0})) begin
			carry   = 3'sd1;
			tm_full = t_s1 - $signed({2'b00, MIN_PER_DAY});
		end else begin
			carry   = 3'sd2;
			tm_full = t_s1 - $signed({1'b0, MIN_PER_DAY, 1'b0});
		end
	end

	assign h_prod   = 23'(tm_s2) * 23'(HOUR_RECIP);
	assign min_full = tm_s3 - 11'(hour_s3) * 11'd60;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= t_sum;
			sec_s1   <= sec_wrap ? utc_second - 6'd60 : utc_second;

			tm_s2    <= tm_full[10:0];
			carry_s2 <= carry;
			sec_s2   <= sec_s1;

			tm_s3    <= tm_s2;
			carry_s3 <= carry_s2;
			sec_s3   <= sec_s2;
			hour_s3  <= h_prod[21:17];

			hms_s[4].hour   <= hour_s3;
			hms_s[4].minute <= min_full[5:0];
			hms_s[4].second <= sec_s3;
			for (int i = 5; i <= NUM_STAGES; i++) begin
				hms_s[i] <= hms_s[i-1];
			end
		end
	end

	utcl_civil_days u_civil_days (
		.clk    (clk),
		.en     (en),
		.year   (utc_year),
		.month  (utc_month),
		.day    (utc_day),
		.era_s3 (era_s3),
		.doe_s3 (doe_s3)
	);

	assign days_s3.era   = era_s3;
	assign days_s3.doe   = doe_s3;
	assign days_s3.carry = carry_s3;

	utcl_days_civil u_days_civil (
		.clk      (clk),
		.en       (en),
		.days_s3  (days_s3),
		.year_s9  (local_year),
		.month_s9 (local_month),
		.day_s9   (local_day)
	);

	assign local_hour   = hms_s[NUM_STAGES].hour;
	assign local_minute = hms_s[NUM_STAGES].minute;
	assign local_second = hms_s[NUM_STAGES].second;

endmodule

@@ rtl/utcl_civil_days.sv @@
// ----------------------------------------------------------------------------
// utcl_civil_days
// Front end of the date path: year, month and day to era and day of era,
// three register stages.
// ----------------------------------------------------------------------------
module utcl_civil_days (
	input  logic               clk,
	input  logic               en,
	input  logic [13:0]        year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	output logic signed [6:0]  era_s3,
	output logic signed [18:0] doe_s3
);
	import utcl_pkg::*;

	logic               month_low;
	logic signed [14:0] ym;
	logic [27:0]        era_prod;
	logic [3:0]         mi;
	logic signed [10:0] doy_full;
	logic signed [15:0] yoe_full;

	logic signed [14:0] ym_s1;
	logic signed [6:0]  era_s1;
	logic signed [9:0]  doy_s1;
	logic signed [6:0]  era_s2;
	logic signed [9:0]  doy_s2;
	logic [8:0]         yoe_s2;

	// January and February count as months of the year before.
	assign month_low = (month <= 4'd2);
	assign ym        = $signed({1'b0, year}) - $signed({14'b0, month_low});
	assign era_prod  = 28'(ym[13:0]) * 28'(ERA_RECIP);
	assign mi        = month_low ? month + 4'd9 : month - 4'd3;
	assign doy_full  = $signed({2'b00, month_start(mi)}) + $signed({6'b0, day}) - 11'sd1;

	assign yoe_full  = 16'(ym_s1) - 16'(era_s1) * 16'sd400;

	always_ff @(posedge clk) begin
		if (en) begin
			ym_s1  <= ym;
			era_s1 <= ym[14] ? -7'sd1 : $signed({1'b0, era_prod[27:22]});
			doy_s1 <= doy_full[9:0];

			era_s2 <= era_s1;
			doy_s2 <= doy_s1;
			yoe_s2 <= yoe_full[8:0];

			era_s3 <= era_s2;
			doe_s3 <= $signed({1'b0, year_days(yoe_s2)}) + 19'(doy_s2);
		end
	end

endmodule

@@ rtl/utcl_days_civil.sv @@
// ----------------------------------------------------------------------------
// utcl_days_civil
// Back end of the date path: era and day of era plus the day carry to year,
// month and day, six register stages ending in the output registers.
// ----------------------------------------------------------------------------
module utcl_days_civil (
	input  logic                clk,
	input  logic                en,
	input  utcl_pkg::utcl_days_t days_s3,
	output logic [13:0]         year_s9,
	output logic [3:0]          month_s9,
	output logic [4:0]          day_s9
);
	import utcl_pkg::*;

	logic signed [18:0] d_sum;
	logic signed [18:0] d_wrap;
	logic [35:0]        c_prod;
	logic [2:0]         q36524;
	logic [17:0]        a_full;
	logic [35:0]        y_prod;
	logic [17:0]        doy_full;
	logic [10:0]        mp_num;
	logic [23:0]        mp_prod;
	logic [9:0]         day_full;
	logic signed [15:0] yr_full;
	logic               jan_feb;

	logic signed [6:0]  era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [17:0]        doe_s4, doe_s5, doe_s6;
	logic [17:0]        a_s5;
	logic [8:0]         yoe_s6, yoe_s7, yoe_s8;
	logic [8:0]         doy_s7, doy_s8;
	logic [3:0]         mp_s8;

	// A negative day of era borrows from the era below.
	assign d_sum  = $signed(days_s3.doe) + 19'($signed(days_s3.carry));
	assign d_wrap = d_sum + $signed({1'b0, DAYS_PER_ERA});

	assign c_prod = 36'(doe_s4) * 36'(Q1460_RECIP);

	always_comb begin
		if (doe_s4 >= LAST_DOE) begin
			q36524 = 3'd4;
		end else if (doe_s4 >= DOE_CENT_3) begin
			q36524 = 3'd3;
		end else if (doe_s4 >= DOE_CENT_2) begin
			q36524 = 3'd2;
		end else if (doe_s4 >= DOE_CENT_1) begin
			q36524 = 3'd1;
		end else begin
			q36524 = 3'd0;
		end
	end

	assign a_full   = doe_s4 - 18'(c_prod[35:28]) + 18'(q36524)
			- 18'(doe_s4 == LAST_DOE);
	assign y_prod   = 36'(a_s5) * 36'(YEAR_RECIP);
	assign doy_full = doe_s6 - year_days(yoe_s6);
	assign mp_num   = 11'(doy_s7) * 11'd5 + 11'd2;
	assign mp_prod  = 24'(mp_num) * 24'(MP_RECIP);

	// Shifted months 10 and 11 are January and February of the next year.
	assign jan_feb  = (mp_s8 >= 4'd10);
	assign day_full = 10'(doy_s8) - 10'(month_start(mp_s8)) + 10'd1;
	assign yr_full  = 16'(era_s8) * 16'sd400 + $signed({7'b0, yoe_s8})
			+ $signed({15'b0, jan_feb});

	always_ff @(posedge clk) begin
		if (en) begin
			era_s4   <= d_sum[18] ? $signed(days_s3.era) - 7'sd1 : $signed(days_s3.era);
			doe_s4   <= d_sum[18] ? d_wrap[17:0] : d_sum[17:0];

			era_s5   <= era_s4;
			doe_s5   <= doe_s4;
			a_s5     <= a_full;

			era_s6   <= era_s5;
			doe_s6   <= doe_s5;
			yoe_s6   <= y_prod[34:26];

			era_s7   <= era_s6;
			yoe_s7   <= yoe_s6;
			doy_s7   <= doy_full[8:0];

			era_s8   <= era_s7;
			yoe_s8   <= yoe_s7;
			doy_s8   <= doy_s7;
			mp_s8    <= mp_prod[23:20];

			day_s9   <= day_full[4:0];
			month_s9 <= jan_feb ? mp_s8 - 4'd9 : mp_s8 + 4'd3;
			year_s9  <= yr_full[13:0];
		end
	end

endmodule

@@ verif/tb_utc_to_local_datetime.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utc_to_local_datetime
// Self-checking bench for the UTC to local date and time pipeline. Feeds
// directed corner dates and a large random mix of calendar-correct and
// out-of-range timestamps under several zone offsets. Random idles on the
// input and output sides. Each result beat is compared field by field with
// a local calendar predictor.
// ----------------------------------------------------------------------------
module tb_utc_to_local_datetime;
	import utcl_pkg::NUM_STAGES;

	localparam int STALL_LIMIT     = 2000;
	localparam int PHASE_ITEMS     = 244;
	localparam int NUM_PHASES      = 8;
	localparam int SECS_PER_DAY    = 86400;
	localparam int EPOCH_DAYS      = 719468;
	localparam int ERA_DAYS        = 146097;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} stamp_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic signed [10:0] utc_offset_minutes;
	logic               in_valid;
	logic               in_ready;
	logic [13:0]        utc_year;
	logic [3:0]         utc_month;
	logic [4:0]         utc_day;
	logic [4:0]         utc_hour;
	logic [5:0]         utc_minute;
	logic [5:0]         utc_second;
	logic               out_valid;
	logic               out_ready;
	logic [13:0]        local_year;
	logic [3:0]         local_month;
	logic [4:0]         local_day;
	logic [4:0]         local_hour;
	logic [5:0]         local_minute;
	logic [5:0]         local_second;

	int idle_cycles;

	utc_to_local_datetime DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.utc_offset_minutes (utc_offset_minutes),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.utc_year           (utc_year),
		.utc_month          (utc_month),
		.utc_day            (utc_day),
		.utc_hour           (utc_hour),
		.utc_minute         (utc_minute),
		.utc_second         (utc_second),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.local_year         (local_year),
		.local_month        (local_month),
		.local_day          (local_day),
		.local_hour         (local_hour),
		.local_minute       (local_minute),
		.local_second       (local_second)
	);

	class local_time_board;
		stamp_t expected_q[$];
		longint offset_min;
		int     errors;
		int     checked;

		function new();
			offset_min = 0;
			errors     = 0;
			checked    = 0;
		endfunction

		function void set_offset(logic signed [10:0] v);
			offset_min = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function longint div_floor(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && ((a < 0) != (b < 0))) q -= 1;
			return q;
		endfunction

		// Days since 1970-01-01; March-based year so the leap day falls last.
		function longint day_count(longint y, longint m, longint d);
			longint era, yoe, doy, doe, mi;
			if (m <= 2) y -= 1;
			era = div_floor(y, 400);
			yoe = y - era * 400;
			mi  = (m > 2) ? m - 3 : m + 9;
			doy = (153 * mi + 2) / 5 + d - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			return era * ERA_DAYS + doe - EPOCH_DAYS;
		endfunction

		function void split_days(longint z, output longint y, output longint m,
				output longint d);
			longint era, doe, yoe, doy, mp;
			z   += EPOCH_DAYS;
			era = div_floor(z, ERA_DAYS);
			doe = z - era * ERA_DAYS;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp  = (5 * doy + 2) / 153;
			d   = doy - (153 * mp + 2) / 5 + 1;
			m   = (mp < 10) ? mp + 3 : mp - 9;
			y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
		endfunction

		function stamp_t to_local(stamp_t u);
			stamp_t r;
			longint yr, mo, dy, hr, mn, sc, days, secs, carry, ly, lm, ld;
			yr = u.year;
			mo = u.month;
			dy = u.day;
			hr = u.hour;
			mn = u.minute;
			sc = u.second;
			days  = day_count(yr, mo, dy);
			secs  = hr * 3600 + mn * 60 + sc + offset_min * 60;
			carry = div_floor(secs, SECS_PER_DAY);
			days  += carry;
			secs  -= carry * SECS_PER_DAY;
			split_days(days, ly, lm, ld);
			// year keeps only its low 14 bits, so -1 reads as 16383
			r.year   = ly[13:0];
			r.month  = lm[3:0];
			r.day    = ld[4:0];
			r.hour   = 5'(secs / 3600);
			r.minute = 6'((secs % 3600) / 60);
			r.second = 6'(secs % 60);
			return r;
		endfunction

		function void note_utc(stamp_t u);
			expected_q.push_back(to_local(u));
		endfunction

		function void report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void cmp(string name, logic [13:0] got, logic [13:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0d want %0d", checked, name, got, want));
		endfunction

		function void check_local(stamp_t got);
			stamp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat with nothing outstanding: %0d-%0d-%0d",
					got.year, got.month, got.day));
				return;
			end
			want = expected_q.pop_front();
			cmp("year",   got.year,   want.year);
			cmp("month",  got.month,  want.month);
			cmp("day",    got.day,    want.day);
			cmp("hour",   got.hour,   want.hour);
			cmp("minute", got.minute, want.minute);
			cmp("second", got.second, want.second);
			checked++;
		endfunction
	endclass

	local_time_board board = new();

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check before noting: a result never belongs to the beat taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_local({local_year, local_month, local_day,
					local_hour, local_minute, local_second});
			if (in_valid && in_ready)
				board.note_utc({utc_year, utc_month, utc_day,
					utc_hour, utc_minute, utc_second});
			if (cfg_valid && cfg_ready)
				board.set_offset(utc_offset_minutes);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Output side: segments of random stalls, some segments stall-free.
	initial begin
		int hold;
		int seg;
		bit calm_rx;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			calm_rx = ($urandom_range(0, 3) == 0);
			seg = $urandom_range(50, 400);
			repeat (seg) begin
				@(negedge clk);
				if (hold > 0) begin
					out_ready <= 1'b0;
					hold--;
				end else begin
					out_ready <= 1'b1;
					if (!calm_rx) hold = pick_gap();
				end
			end
		end
	end

	function automatic stamp_t mk(int y, int mo, int d, int h, int mi, int s);
		return {14'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s)};
	endfunction

	// Mostly real calendar dates, biased to month ends and midnight; the rest noise.
	function automatic stamp_t utc_sample();
		stamp_t s;
		int r, y, mo, len;
		bit leap;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			s = stamp_t'(40'({$urandom, $urandom}));
			return s;
		end
		if (r < 27) begin
			case ($urandom_range(0, 5))
				0: y = 0;
				1: y = 1;
				2: y = 9999;
				3: y = 16383;
				4: y = $urandom_range(10000, 16383);
				default: y = $urandom_range(0, 99) * 100;
			endcase
		end else begin
			y = $urandom_range(1, 9999);
		end
		mo = $urandom_range(1, 12);
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		case (mo)
			2:          len = leap ? 29 : 28;
			4, 6, 9, 11: len = 30;
			default:    len = 31;
		endcase
		s.year  = 14'(y);
		s.month = 4'(mo);
		case ($urandom_range(0, 9))
			0, 1:    s.day = 5'(len);
			2:       s.day = 5'd1;
			default: s.day = 5'($urandom_range(1, len));
		endcase
		if ($urandom_range(0, 2) == 0) begin
			s.hour   = $urandom_range(0, 1) ? 5'd23 : 5'd0;
			s.minute = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
		end else begin
			s.hour   = 5'($urandom_range(0, 23));
			s.minute = 6'($urandom_range(0, 59));
		end
		s.second = 6'($urandom_range(0, 59));
		// break one field of an otherwise valid stamp
		if (r >= 92) begin
			case ($urandom_range(0, 4))
				0: s.month  = 4'($urandom);
				1: s.day    = 5'($urandom);
				2: s.hour   = 5'($urandom);
				3: s.minute = 6'($urandom);
				default: s.second = 6'($urandom);
			endcase
		end
		return s;
	endfunction

	task automatic send(input stamp_t s);
		@(negedge clk);
		in_valid <= 1'b1;
		{utc_year, utc_month, utc_day, utc_hour, utc_minute, utc_second} <= s;
		do begin
			@(posedge clk);
		end while (in_ready !== 1'b1);
	endtask

	task automatic idle_in(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drain();
		idle_in(1);
		while (board.pending() != 0) @(negedge clk);
	endtask

	task automatic write_offset(input logic signed [10:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		utc_offset_minutes <= v;
		do begin
			@(posedge clk);
		end while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int gap;
		bit calm_tx;
		int offsets[NUM_PHASES];
		arst_n             = 1'b0;
		cfg_valid          = 1'b0;
		utc_offset_minutes = '0;
		in_valid           = 1'b0;
		{utc_year, utc_month, utc_day, utc_hour, utc_minute, utc_second} = '0;
		calm_tx            = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Offset at its reset value of zero.
		send(mk(1970, 1, 1, 0, 0, 0));
		send(mk(1, 1, 1, 0, 0, 0));
		send(mk(9999, 12, 31, 23, 59, 59));
		send(mk(2000, 2, 29, 12, 34, 56));
		send(mk(1900, 2, 29, 6, 0, 0));
		send(mk(2024, 0, 15, 8, 30, 0));
		send(mk(2023, 13, 1, 0, 0, 1));
		send(mk(2023, 15, 31, 23, 59, 59));
		send(mk(2024, 3, 0, 12, 0, 0));
		send(mk(2023, 2, 31, 1, 2, 3));
		send(mk(2021, 6, 15, 31, 63, 63));
		send(mk(0, 1, 1, 0, 0, 0));
		send(mk(16383, 15, 31, 31, 63, 63));
		send(mk(0, 0, 0, 0, 0, 0));
		send(mk(2100, 2, 28, 23, 59, 59));

		// West edge: day borrows across the year and the leap day.
		write_offset(11'(-720));
		send(mk(1, 1, 1, 0, 0, 0));
		send(mk(2024, 3, 1, 11, 59, 59));
		send(mk(0, 1, 1, 0, 0, 0));

		// East edge: carries into year 10000 and past the 14-bit field.
		write_offset(11'(840));
		send(mk(9999, 12, 31, 10, 0, 0));
		send(mk(16383, 12, 31, 23, 0, 0));
		send(mk(2023, 2, 28, 10, 0, 0));

		offsets[0] = -720;
		offsets[1] = 840;
		offsets[2] = -1024;
		offsets[3] = 1023;
		offsets[4] = 0;
		offsets[5] = $urandom_range(0, 1560) - 720;
		offsets[6] = $urandom_range(0, 2047);
		offsets[7] = $urandom_range(0, 1560) - 720;

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_offset(11'(offsets[p]));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0) calm_tx = ($urandom_range(0, 3) == 0);
				// hold off now and then until the pipeline is empty
				if ($urandom_range(0, 149) == 0) drain();
				gap = calm_tx ? 0 : pick_gap();
				if (gap > 0) idle_in(gap);
				send(utc_sample());
			end
		end

		drain();
		repeat (NUM_STAGES + 4) @(negedge clk);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
